### rtl/core/desq_pkg.sv
// Shared types and codes for the double-ended sorted priority queue.
package desq_pkg;

    localparam int PRIO_W   = 16;
    localparam int AGE_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REM_HIGH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REM_LOW  = 2'd2;

    // result status codes carried in the output tuser
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EDGE_CAP,
        S_REPORT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input item
        logic set_full;   // status full, nothing changes
        logic set_empty;  // status empty, nothing changes
        logic ins_first;  // insert into an empty store
        logic ins_start;  // start walk from the tail
        logic shift_rd;   // read the entry above the walk pointer
        logic shift_wr;   // move that entry down one slot
        logic place;      // write the new entry at the walk pointer
        logic take;       // remove the top or bottom entry
        logic edge_cap;   // capture the new top or bottom from the read
        logic report;     // load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              single;
        logic              left_zero;
        logic              greater;
        logic              out_free;
    } t_stat;

endpackage

### rtl/core/double_ended_sorted_priority_queue_top.sv
// Top level of the double-ended sorted priority queue.
//
//  channel  | direction | handshake                       | contents
//  ---------+-----------+---------------------------------+---------------------------
//  s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | operation and new entry
//  m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | status, removed and edges
//
// One operation is in flight at a time. An insert walks the single-port store
// from the tail, with one read and then one write for each entry moved down
// one slot; a removal that must fetch the new top or bottom reads it from the
// store. The controller returns to its idle step after each result and
// accepts the next input transfer there.
// Reset (synchronous, active low) empties the store; no clearing pass is
// needed as only slots between head and tail are ever read.
// The result sits in its own register; a stalled output holds the controller
// in its report step until the result transfer frees that register.
module double_ended_sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] new_priority, [23:16] new_age
    input  logic [23:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] taken_priority, [23:16] taken_age, [28:24] entry_count,
    // [44:29] top_priority, [52:45] top_age, [68:53] bottom_priority,
    // [76:69] bottom_age, [79:77] zero
    output logic [79:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser
);

    desq_pkg::t_cmd   cmd;
    desq_pkg::t_stat  stat;
    desq_pkg::t_entry taken, top, bottom;
    logic [desq_pkg::COUNT_W-1:0] count;

    desq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    desq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_s_axis_tuser),
        .i_prio      (i_s_axis_tdata[15:0]),
        .i_age       (i_s_axis_tdata[23:16]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (o_m_axis_tuser),
        .o_taken     (taken),
        .o_count     (count),
        .o_top       (top),
        .o_bottom    (bottom)
    );

    // result packing, highest field first
    assign o_m_axis_tdata = {3'b000, bottom.age, bottom.prio, top.age, top.prio,
                             count, taken.age, taken.prio};

endmodule

### rtl/core/desq_datapath.sv
// Datapath: circular sorted store, edge registers and result register.
module desq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  desq_pkg::t_cmd                i_cmd,
    output desq_pkg::t_stat               o_stat,
    input  logic [desq_pkg::KIND_W-1:0]   i_kind,
    input  logic [desq_pkg::PRIO_W-1:0]   i_prio,
    input  logic [desq_pkg::AGE_W-1:0]    i_age,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [desq_pkg::STATUS_W-1:0] o_status,
    output desq_pkg::t_entry              o_taken,
    output logic [desq_pkg::COUNT_W-1:0]  o_count,
    output desq_pkg::t_entry              o_top,
    output desq_pkg::t_entry              o_bottom
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    desq_pkg::t_entry mem [DEPTH];

    logic [AW-1:0]                   r_head, r_tail, r_ptr;
    logic [CW-1:0]                   r_count, r_left;
    logic                            r_moved;
    logic [desq_pkg::KIND_W-1:0]     r_kind;
    desq_pkg::t_entry                r_new, r_rd, r_top, r_bot, r_taken;
    logic [desq_pkg::STATUS_W-1:0]   r_status;
    logic                            r_out_valid;
    logic [desq_pkg::STATUS_W-1:0]   r_o_status;
    desq_pkg::t_entry                r_o_taken, r_o_top, r_o_bot;
    logic [desq_pkg::COUNT_W-1:0]    r_o_count;

    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en;
    desq_pkg::t_entry wr_data;
    logic [31:0]      count_ext;

    assign o_stat.kind      = r_kind;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.single    = (r_count == CW'(1));
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.greater   = ($signed(r_rd.prio) > $signed(r_new.prio));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // one read port: walk read, else the slot that becomes the new edge
    always_comb begin
        if (i_cmd.shift_rd) begin
            rd_addr = dec_ptr(r_ptr);
        end else if (r_kind == desq_pkg::KIND_REM_HIGH) begin
            rd_addr = inc_ptr(r_head);
        end else begin
            rd_addr = dec_ptr(dec_ptr(r_tail));
        end
    end

    always_comb begin
        wr_en   = i_cmd.ins_first || i_cmd.place || i_cmd.shift_wr;
        wr_addr = i_cmd.ins_first ? r_tail : r_ptr;
        wr_data = i_cmd.shift_wr ? r_rd : r_new;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_first || i_cmd.place) begin
                r_tail  <= inc_ptr(r_tail);
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.take) begin
                if (r_kind == desq_pkg::KIND_REM_HIGH) begin
                    r_head <= inc_ptr(r_head);
                end else begin
                    r_tail <= dec_ptr(r_tail);
                end
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_new.prio <= i_prio;
            r_new.age  <= i_age;
            r_status   <= desq_pkg::STATUS_OK;
            r_taken    <= '0;
        end
        if (i_cmd.set_full) begin
            r_status <= desq_pkg::STATUS_FULL;
        end
        if (i_cmd.set_empty) begin
            r_status <= desq_pkg::STATUS_EMPTY;
        end
        if (i_cmd.ins_first) begin
            r_top <= r_new;
            r_bot <= r_new;
        end
        if (i_cmd.ins_start) begin
            r_ptr   <= r_tail;
            r_left  <= r_count;
            r_moved <= 1'b0;
        end
        if (i_cmd.shift_wr) begin
            r_ptr   <= dec_ptr(r_ptr);
            r_left  <= r_left - CW'(1);
            r_moved <= 1'b1;
        end
        if (i_cmd.place) begin
            if (r_left == '0) begin
                r_top <= r_new;
            end
            if (!r_moved) begin
                r_bot <= r_new;
            end
        end
        if (i_cmd.take) begin
            r_taken <= (r_kind == desq_pkg::KIND_REM_HIGH) ? r_top : r_bot;
        end
        if (i_cmd.edge_cap) begin
            if (r_kind == desq_pkg::KIND_REM_HIGH) begin
                r_top <= r_rd;
            end else begin
                r_bot <= r_rd;
            end
        end
        if (i_cmd.report) begin
            r_o_status <= r_status;
            r_o_taken  <= r_taken;
            r_o_count  <= count_ext[desq_pkg::COUNT_W-1:0];
            r_o_top    <= (r_count == '0) ? '0 : r_top;
            r_o_bot    <= (r_count == '0) ? '0 : r_bot;
        end
    end

    assign count_ext = 32'(r_count);

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_taken     = r_o_taken;
    assign o_count     = r_o_count;
    assign o_top       = r_o_top;
    assign o_bottom    = r_o_bot;

endmodule

### rtl/core/desq_ctrl.sv
// Controller: sequences one queue operation at a time.
module desq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  desq_pkg::t_stat i_stat,
    output desq_pkg::t_cmd  o_cmd
);

    desq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= desq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            desq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = desq_pkg::S_DECIDE;
                end
            end
            desq_pkg::S_DECIDE: begin
                unique case (i_stat.kind) inside
                    desq_pkg::KIND_INSERT: begin
                        if (i_stat.full || i_stat.empty) begin
                            n_state = desq_pkg::S_REPORT;
                        end else begin
                            n_state = desq_pkg::S_SHIFT_RD;
                        end
                    end
                    desq_pkg::KIND_REM_HIGH, desq_pkg::KIND_REM_LOW: begin
                        if (i_stat.empty || i_stat.single) begin
                            n_state = desq_pkg::S_REPORT;
                        end else begin
                            n_state = desq_pkg::S_EDGE_CAP;
                        end
                    end
                    default: n_state = desq_pkg::S_REPORT;
                endcase
            end
            desq_pkg::S_SHIFT_RD: begin
                n_state = i_stat.left_zero ? desq_pkg::S_REPORT : desq_pkg::S_SHIFT_WR;
            end
            desq_pkg::S_SHIFT_WR: begin
                n_state = i_stat.greater ? desq_pkg::S_REPORT : desq_pkg::S_SHIFT_RD;
            end
            desq_pkg::S_EDGE_CAP: n_state = desq_pkg::S_REPORT;
            desq_pkg::S_REPORT: begin
                if (i_stat.out_free) begin
                    n_state = desq_pkg::S_IDLE;
                end
            end
            default: n_state = desq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            desq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            desq_pkg::S_DECIDE: begin
                unique case (i_stat.kind) inside
                    desq_pkg::KIND_INSERT: begin
                        o_cmd.set_full  = i_stat.full;
                        o_cmd.ins_first = !i_stat.full && i_stat.empty;
                        o_cmd.ins_start = !i_stat.full && !i_stat.empty;
                    end
                    desq_pkg::KIND_REM_HIGH, desq_pkg::KIND_REM_LOW: begin
                        o_cmd.set_empty = i_stat.empty;
                        o_cmd.take      = !i_stat.empty;
                    end
                    default: ;
                endcase
            end
            desq_pkg::S_SHIFT_RD: begin
                o_cmd.place    = i_stat.left_zero;
                o_cmd.shift_rd = !i_stat.left_zero;
            end
            desq_pkg::S_SHIFT_WR: begin
                o_cmd.place    = i_stat.greater;
                o_cmd.shift_wr = !i_stat.greater;
            end
            desq_pkg::S_EDGE_CAP: o_cmd.edge_cap = 1'b1;
            desq_pkg::S_REPORT:   o_cmd.report   = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
